// ----- design/arfcm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and palette function for the auto-range colour map.
// No dependencies.
package arfcm_pkg;

  localparam int unsigned SampleWidth = 32;
  localparam int unsigned FieldWidth  = 32;
  localparam int unsigned IndexWidth  = 10;
  localparam int unsigned CntWidth    = $clog2(IndexWidth);
  localparam int unsigned ColourWidth = 8;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [IndexWidth-1:0]         index_t;
  typedef logic [ColourWidth-1:0]        colour_t;

  localparam sample_t SampleMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleWidth-1){1'b0}}};
  localparam index_t  IndexMax  = '1;

  localparam logic OpMeasure = 1'b0;
  localparam logic OpConvert = 1'b1;

  typedef struct packed {
    logic idle;
    logic done;
  } div_stat_t;

  typedef struct packed {
    colour_t red;
    colour_t green;
    colour_t blue;
  } rgb_t;

  // Four segments: blue-cyan, cyan-green, green-yellow, yellow-red.
  function automatic rgb_t palette(input index_t k);
    rgb_t c;
    colour_t f;
    f = k[ColourWidth-1:0];
    case (k[IndexWidth-1:IndexWidth-2])
      2'd0: begin
        c = '{red: '0, green: f, blue: '1};
      end
      2'd1: begin
        c = '{red: '0, green: '1, blue: ~f};
      end
      2'd2: begin
        c = '{red: f, green: '1, blue: '0};
      end
      default: begin
        c = '{red: '1, green: ~f, blue: '0};
      end
    endcase
    return c;
  endfunction

endpackage

// ----- design/auto_range_false_color_map.sv -----
`timescale 1ns / 1ps
// Top level of the auto-range false-colour map: range tracker, divider, result register.
// Depends on arfcm_pkg, arfcm_range, arfcm_div.
//
//  channel | handshake             | payload
//  in      | in_valid_i/in_ready_o | operation_i, frame_start_i, sample_i
//  out     | out_valid_o/out_ready_i | red_o, green_o, blue_o, palette_index_o
//
// A measure request only updates the range and leaves the divider idle. A convert
// request runs three range checks and ten quotient steps on the one subtractor,
// then a done state; an early range exit ends sooner.
// in_ready_o is high only while the divider is idle; a finished index waits in
// the divider until the result register is free.
// Reset sets the range to empty and clears the result register valid.
module auto_range_false_color_map import arfcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic                  frame_start_i,
  input  logic [FieldWidth-1:0] sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output colour_t               red_o,
  output colour_t               green_o,
  output colour_t               blue_o,
  output index_t                palette_index_o
);

  div_stat_t div_stat;
  index_t    div_index;
  sample_t   sample, low, high;
  logic      accept, load, out_valid_q;
  rgb_t      rgb_q;
  index_t    index_q;

  assign sample     = sample_t'(sample_i[SampleWidth-1:0]);
  assign in_ready_o = div_stat.idle;
  assign accept     = in_valid_i && in_ready_o;
  assign load       = div_stat.done && (!out_valid_q || out_ready_i);

  arfcm_range u_range (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .update_i  (accept && (operation_i == OpMeasure)),
    .restart_i (frame_start_i),
    .sample_i  (sample),
    .low_o     (low),
    .high_o    (high)
  );

  arfcm_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && (operation_i == OpConvert)),
    .sample_i (sample),
    .low_i    (low),
    .high_i   (high),
    .ack_i    (load),
    .stat_o   (div_stat),
    .index_o  (div_index)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rgb_q   <= palette(div_index);
      index_q <= div_index;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_o           = rgb_q.red;
  assign green_o         = rgb_q.green;
  assign blue_o          = rgb_q.blue;
  assign palette_index_o = index_q;

endmodule

// ----- design/arfcm_range.sv -----
`timescale 1ns / 1ps
// Running minimum and maximum of the measured samples.
// Depends on arfcm_pkg.
module arfcm_range import arfcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    update_i,
  input  logic    restart_i,
  input  sample_t sample_i,
  output sample_t low_o,
  output sample_t high_o
);

  sample_t low_q, high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= SampleMax;
      high_q <= SampleMin;
    end else if (update_i) begin
      if (restart_i) begin
        low_q  <= sample_i;
        high_q <= sample_i;
      end else begin
        if (sample_i < low_q) low_q <= sample_i;
        if (sample_i > high_q) high_q <= sample_i;
      end
    end
  end

  assign low_o  = low_q;
  assign high_o = high_q;

endmodule

// ----- design/arfcm_div.sv -----
`timescale 1ns / 1ps
// Normalising divider: range checks and one quotient bit a cycle through a
// single shared subtractor. Depends on arfcm_pkg.
module arfcm_div import arfcm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  sample_t   sample_i,
  input  sample_t   low_i,
  input  sample_t   high_i,
  input  logic      ack_i,
  output div_stat_t stat_o,
  output index_t    index_o
);

  typedef enum logic [2:0] {
    StIdle,
    StSpan,
    StOffset,
    StTop,
    StIter,
    StDone
  } state_e;

  typedef logic signed [SampleWidth+1:0] wide_t;

  state_e                 state_q;
  sample_t                v_q, lo_q, hi_q;
  logic [SampleWidth-1:0] r_q, rem_q;
  index_t                 q_q;
  logic [CntWidth-1:0]    cnt_q;

  wide_t op_a, op_b, diff;
  logic  diff_neg, diff_zero;

  // shared subtractor
  always_comb begin
    case (state_q)
      StSpan: begin
        op_a = {{2{hi_q[SampleWidth-1]}}, hi_q};
        op_b = {{2{lo_q[SampleWidth-1]}}, lo_q};
      end
      StOffset: begin
        op_a = {{2{v_q[SampleWidth-1]}}, v_q};
        op_b = {{2{lo_q[SampleWidth-1]}}, lo_q};
      end
      StTop: begin
        op_a = {{2{v_q[SampleWidth-1]}}, v_q};
        op_b = {{2{hi_q[SampleWidth-1]}}, hi_q};
      end
      default: begin
        op_a = {1'b0, rem_q, 1'b0};
        op_b = {2'b00, r_q};
      end
    endcase
  end

  assign diff      = op_a - op_b;
  assign diff_neg  = diff[SampleWidth+1];
  assign diff_zero = (diff == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      q_q     <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) begin
            v_q     <= sample_i;
            lo_q    <= low_i;
            hi_q    <= high_i;
            q_q     <= '0;
            cnt_q   <= '0;
            state_q <= StSpan;
          end
        end
        StSpan: begin
          r_q <= diff[SampleWidth-1:0];
          if (diff_neg || diff_zero) state_q <= StDone;
          else state_q <= StOffset;
        end
        StOffset: begin
          rem_q <= diff[SampleWidth-1:0];
          if (diff_neg || diff_zero) state_q <= StDone;
          else state_q <= StTop;
        end
        StTop: begin
          if (!diff_neg) begin
            q_q     <= IndexMax;
            state_q <= StDone;
          end else begin
            state_q <= StIter;
          end
        end
        StIter: begin
          q_q <= {q_q[IndexWidth-2:0], !diff_neg};
          if (diff_neg) rem_q <= {rem_q[SampleWidth-2:0], 1'b0};
          else rem_q <= diff[SampleWidth-1:0];
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntWidth'(IndexWidth - 1)) state_q <= StDone;
        end
        StDone: begin
          if (ack_i) state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign stat_o.idle = (state_q == StIdle);
  assign stat_o.done = (state_q == StDone);
  assign index_o     = q_q;

endmodule

// ----- design/arfcm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the auto-range colour map, bound to the top level.
// Depends on arfcm_pkg.
module arfcm_checker import arfcm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  operation_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input colour_t               red_o,
  input colour_t               green_o,
  input colour_t               blue_o,
  input index_t                palette_index_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(palette_index_o))
    else $error("result changed while stalled");

  a_measure_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == OpMeasure) |=> !$rose(out_valid_o))
    else $error("measure request produced a result");

  a_convert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == OpConvert) |=> !in_ready_o)
    else $error("ready during conversion");

  a_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (palette_index_o[9:8] == 2'd0 && red_o == 8'd0 && blue_o == 8'd255 &&
       green_o == palette_index_o[7:0]) ||
      (palette_index_o[9:8] == 2'd1 && red_o == 8'd0 && green_o == 8'd255 &&
       blue_o == ~palette_index_o[7:0]) ||
      (palette_index_o[9:8] == 2'd2 && blue_o == 8'd0 && green_o == 8'd255 &&
       red_o == palette_index_o[7:0]) ||
      (palette_index_o[9:8] == 2'd3 && blue_o == 8'd0 && red_o == 8'd255 &&
       green_o == ~palette_index_o[7:0]))
    else $error("colour does not match index");

endmodule

bind auto_range_false_color_map arfcm_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .operation_i     (operation_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .red_o           (red_o),
  .green_o         (green_o),
  .blue_o          (blue_o),
  .palette_index_o (palette_index_o)
);

// ----- tb/auto_range_false_color_map_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for auto_range_false_color_map: a directed part, then random
// frames of measure and convert requests and loose random requests, with stalls on both channels.
// Depends on arfcm_pkg and the design sources.
module auto_range_false_color_map_test;
  import arfcm_pkg::*;

  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned ItemTarget = 800;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  operation_i;
  logic                  frame_start_i;
  logic [FieldWidth-1:0] sample_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  colour_t               red_o;
  colour_t               green_o;
  colour_t               blue_o;
  index_t                palette_index_o;

  auto_range_false_color_map i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .frame_start_i  (frame_start_i),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .palette_index_o(palette_index_o)
  );

  class colour_scoreboard;
    typedef struct {
      colour_t red;
      colour_t green;
      colour_t blue;
      index_t  idx;
    } pixel_t;

    sample_t     range_low;
    sample_t     range_high;
    pixel_t      pending[$];
    int unsigned errors;

    function new();
      range_low  = SampleMax;
      range_high = SampleMin;
      errors     = 0;
    endfunction

    task report(input string msg);
      $display("%0t ERROR: %s", $realtime, msg);
      errors++;
    endtask

    function index_t scaled_index(input sample_t v);
      longint span;
      longint offs;
      if (range_high <= range_low || v <= range_low) begin
        return '0;
      end
      if (v >= range_high) begin
        return IndexMax;
      end
      span = longint'(range_high) - longint'(range_low);
      offs = longint'(v) - longint'(range_low);
      return index_t'((offs * 1024) / span);
    endfunction

    function void note_request(input logic op, input logic fs, input sample_t v);
      pixel_t p;
      int     k;
      if (op == OpMeasure) begin
        if (fs) begin
          range_low  = v;
          range_high = v;
        end else begin
          if (v < range_low) range_low = v;
          if (v > range_high) range_high = v;
        end
        return;
      end
      p.idx = scaled_index(v);
      k = int'(p.idx);
      if (k < 256) begin
        p.red = 8'd0;   p.green = colour_t'(k);        p.blue = 8'd255;
      end else if (k < 512) begin
        p.red = 8'd0;   p.green = 8'd255;              p.blue = colour_t'(511 - k);
      end else if (k < 768) begin
        p.red = colour_t'(k - 512); p.green = 8'd255;  p.blue = 8'd0;
      end else begin
        p.red = 8'd255; p.green = colour_t'(1023 - k); p.blue = 8'd0;
      end
      pending.push_back(p);
    endfunction

    task check_pixel(input colour_t r, input colour_t g, input colour_t b, input index_t k);
      pixel_t p;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result idx=%0d rgb=%0d,%0d,%0d", k, r, g, b));
        return;
      end
      p = pending.pop_front();
      if (k != p.idx) report($sformatf("palette_index %0d, want %0d", k, p.idx));
      if (r != p.red) report($sformatf("red %0d, want %0d (idx %0d)", r, p.red, p.idx));
      if (g != p.green) report($sformatf("green %0d, want %0d (idx %0d)", g, p.green, p.idx));
      if (b != p.blue) report($sformatf("blue %0d, want %0d (idx %0d)", b, p.blue, p.idx));
    endtask

    task drain_check();
      if (pending.size() != 0) report($sformatf("%0d results never arrived", pending.size()));
    endtask
  endclass

  colour_scoreboard sb = new();
  int unsigned      idle_cycles;
  int unsigned      sent;
  bit               burst;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 4))
      0: return SampleMin + sample_t'($urandom_range(0, 15));
      1: return SampleMax - sample_t'($urandom_range(0, 15));
      2: return sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // valid stays high across back-to-back requests
  task automatic send_request(input logic op, input logic fs, input sample_t v);
    int unsigned gap;
    gap = pick_gap(burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    frame_start_i <= fs;
    sample_i      <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, fs, v);
    sent++;
  endtask

  task automatic send_frame();
    sample_t     base;
    sample_t     v;
    int unsigned spread;
    int unsigned n_meas;
    int unsigned n_conv;
    bit          wide;
    wide   = ($urandom_range(0, 3) == 0);
    base   = rand_sample();
    spread = 1 << $urandom_range(0, 24);
    n_meas = $urandom_range(1, 8);
    n_conv = $urandom_range(1, 10);
    for (int i = 0; i < n_meas; i++) begin
      v = wide ? rand_sample() : base + sample_t'($urandom_range(0, spread));
      send_request(OpMeasure, i == 0, v);
    end
    for (int i = 0; i < n_conv; i++) begin
      case ($urandom_range(0, 9))
        0: v = rand_sample();
        1: v = base - sample_t'($urandom_range(0, spread));
        2: v = sb.range_low;
        3: v = sb.range_high;
        default: v = wide ? rand_sample() : base + sample_t'($urandom_range(0, spread));
      endcase
      send_request(OpConvert, 1'($urandom_range(0, 1)), v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_pixel(red_o, green_o, blue_o, palette_index_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      gap = pick_gap($urandom_range(0, 4) == 0);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    idle_cycles   = 0;
    sent          = 0;
    burst         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    operation_i   = OpMeasure;
    frame_start_i = 1'b0;
    sample_i      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty range after reset, then a measure without frame start
    send_request(OpConvert, 1'b0, sample_t'(100));
    send_request(OpMeasure, 1'b0, sample_t'(0));
    send_request(OpConvert, 1'b1, sample_t'(0));
    // range 0..1024: index equals sample below 1024, covers every palette segment edge
    send_request(OpMeasure, 1'b0, sample_t'(1024));
    send_request(OpConvert, 1'b0, sample_t'(0));
    send_request(OpConvert, 1'b0, sample_t'(255));
    send_request(OpConvert, 1'b0, sample_t'(256));
    send_request(OpConvert, 1'b0, sample_t'(511));
    send_request(OpConvert, 1'b0, sample_t'(512));
    send_request(OpConvert, 1'b0, sample_t'(767));
    send_request(OpConvert, 1'b0, sample_t'(768));
    send_request(OpConvert, 1'b0, sample_t'(1023));
    send_request(OpConvert, 1'b0, -sample_t'(5));
    send_request(OpConvert, 1'b0, sample_t'(1024));
    send_request(OpConvert, 1'b0, SampleMax);
    // full-scale range
    send_request(OpMeasure, 1'b1, SampleMin);
    send_request(OpMeasure, 1'b0, SampleMax);
    send_request(OpConvert, 1'b0, sample_t'(0));
    send_request(OpConvert, 1'b0, SampleMin);
    send_request(OpConvert, 1'b0, -sample_t'(1));
    // flat range
    send_request(OpMeasure, 1'b1, sample_t'(7));
    send_request(OpConvert, 1'b0, sample_t'(7));
    send_request(OpConvert, 1'b0, sample_t'(8));

    while (sent < ItemTarget) begin
      burst = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 8) begin
        send_frame();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       sample_t'($urandom));
        end
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    sb.drain_check();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
